// ===== hw/rtl/ptms_pkg.sv =====
// ----------------------------------------------------------------------------
// ptms_pkg
// Shared widths, register indexes, constants and controller/datapath structs
// for the pitch track median smoother.
// ----------------------------------------------------------------------------
package ptms_pkg;

   localparam int PITCH_W     = 20;
   localparam int ALPHA_W     = 16;
   localparam int MEDIAN_TAPS = 5;
   localparam int TAP_IDX_W   = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
   localparam int FILL_W      = $clog2(MEDIAN_TAPS + 1);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PITCH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PITCH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_ALPHA = 2'd2;

   localparam logic [PITCH_W-1:0] MIN_PITCH_RST    = 20'd800;
   localparam logic [PITCH_W-1:0] MAX_PITCH_RST    = 20'd16000;
   localparam logic [ALPHA_W-1:0] SMOOTH_ALPHA_RST = 16'd60000;

   // floor(9*s/10) = (s * 9 * ceil(2^27/10)) >> 27, exact for 9*s < 2^26
   localparam int DECAY_SHIFT  = 27;
   localparam int DECAY_MULT_W = 27;
   localparam logic [DECAY_MULT_W-1:0] DECAY_MULT = 27'd120795957;
   localparam int DECAY_PROD_W = PITCH_W + DECAY_MULT_W;

   // alpha * (s - m), signed
   localparam int SMOOTH_PROD_W = ALPHA_W + PITCH_W + 2;
   localparam int ROUND_HALF    = 32768;

   typedef struct packed {
      logic load;
      logic decay_mul;
      logic decay_fin;
      logic halve;
      logic double_up;
      logic push;
      logic scan;
      logic seed;
      logic smooth_mul;
      logic smooth_fin;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic req_zero;
      logic track_zero;
      logic fold_high;
      logic fold_low;
      logic scan_hit;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/ptms_channels.sv =====
// ----------------------------------------------------------------------------
// ptms channels
// Valid/ready channel interfaces: candidate pitch in, tracked pitch out,
// register write port.
// ----------------------------------------------------------------------------
interface ptms_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptms_pkg::PITCH_W-1:0]  candidate_pitch;

   modport source (output valid, output candidate_pitch, input ready);
   modport sink   (input valid, input candidate_pitch, output ready);
endinterface

interface ptms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ptms_pkg::PITCH_W-1:0]  tracked_pitch;

   modport source (output valid, output tracked_pitch, input ready);
   modport sink   (input valid, input tracked_pitch, output ready);
endinterface

interface ptms_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ptms_pkg::CSR_IDX_W-1:0]   index;
   logic [ptms_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/ptms_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptms_ctrl
// Sequencer: steps one frame through decay (unvoiced) or through octave fold (none if no
// pitch is tracked), ring push, median scan and smoothing or seeding, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ptms_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ptms_pkg::dp_status_type status,
   output ptms_pkg::dp_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_DECAY_MUL  = 4'd1;
   localparam logic [3:0] ST_DECAY_FIN  = 4'd2;
   localparam logic [3:0] ST_FOLD_DN    = 4'd3;
   localparam logic [3:0] ST_FOLD_UP    = 4'd4;
   localparam logic [3:0] ST_PUSH       = 4'd5;
   localparam logic [3:0] ST_SCAN       = 4'd6;
   localparam logic [3:0] ST_SEED       = 4'd7;
   localparam logic [3:0] ST_SMOOTH_MUL = 4'd8;
   localparam logic [3:0] ST_SMOOTH_FIN = 4'd9;
   localparam logic [3:0] ST_EMIT       = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.req_zero) begin
                  state_in = ST_DECAY_MUL;
               end else if (status.track_zero) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_FOLD_DN;
               end
            end
         end
         ST_DECAY_MUL: begin
            cmd.decay_mul = 1'b1;
            state_in      = ST_DECAY_FIN;
         end
         ST_DECAY_FIN: begin
            cmd.decay_fin = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_FOLD_DN: begin
            if (status.fold_high) begin
               cmd.halve = 1'b1;
            end else begin
               state_in = ST_FOLD_UP;
            end
         end
         ST_FOLD_UP: begin
            if (status.fold_low) begin
               cmd.double_up = 1'b1;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_hit) begin
               state_in = status.track_zero ? ST_SEED : ST_SMOOTH_MUL;
            end
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            state_in = ST_EMIT;
         end
         ST_SMOOTH_MUL: begin
            cmd.smooth_mul = 1'b1;
            state_in       = ST_SMOOTH_FIN;
         end
         ST_SMOOTH_FIN: begin
            cmd.smooth_fin = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/ptms_dp.sv =====
// ----------------------------------------------------------------------------
// ptms_dp
// Datapath: tracked pitch, median ring, fold register, decay and smoothing
// multipliers, output register.
// ----------------------------------------------------------------------------
module ptms_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  ptms_pkg::dp_cmd_type              cmd,
   output ptms_pkg::dp_status_type           status,
   input  logic [ptms_pkg::PITCH_W-1:0]      req_pitch,
   input  logic [ptms_pkg::PITCH_W-1:0]      min_pitch,
   input  logic [ptms_pkg::PITCH_W-1:0]      max_pitch,
   input  logic [ptms_pkg::ALPHA_W-1:0]      smooth_alpha,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [ptms_pkg::PITCH_W-1:0]      rsp_pitch
);

   localparam int PW = ptms_pkg::PITCH_W;
   localparam int FW = ptms_pkg::FILL_W;
   localparam int IW = ptms_pkg::TAP_IDX_W;
   localparam int SW = ptms_pkg::SMOOTH_PROD_W;

   logic [PW-1:0] track_ff, track_in;
   logic [PW-1:0] cand_ff, cand_in;
   logic [PW-1:0] med_ff, med_in;
   logic [IW-1:0] wpos_ff, wpos_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [PW-1:0] ring_ff [ptms_pkg::MEDIAN_TAPS];
   logic [ptms_pkg::DECAY_PROD_W-1:0] decay_prod_ff;
   logic signed [SW-1:0] sm_prod_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_pitch_ff;

   // octave fold compares: 10c vs 19s, 19c vs 10s, 2c vs max
   logic [PW+4:0] cand_x10, cand_x19, track_x10, track_x19;
   logic [PW:0]   cand_x2;

   assign cand_x10  = ({5'd0, cand_ff} << 3) + ({5'd0, cand_ff} << 1);
   assign cand_x19  = ({5'd0, cand_ff} << 4) + ({5'd0, cand_ff} << 1) + {5'd0, cand_ff};
   assign track_x10 = ({5'd0, track_ff} << 3) + ({5'd0, track_ff} << 1);
   assign track_x19 = ({5'd0, track_ff} << 4) + ({5'd0, track_ff} << 1) + {5'd0, track_ff};
   assign cand_x2   = {cand_ff, 1'b0};

   // decay result and clear test
   logic [PW-1:0] decay_q;
   logic [PW+1:0] decay_x4;
   assign decay_q  = decay_prod_ff[ptms_pkg::DECAY_SHIFT +: PW];
   assign decay_x4 = {decay_q, 2'b00};

   // smoothing: (m << 16) + alpha*(s - m) + half, >> 16
   logic signed [PW:0]   sm_diff;
   logic signed [SW-1:0] sm_acc;
   logic [PW-1:0]        sm_res;
   assign sm_diff = $signed({1'b0, track_ff}) - $signed({1'b0, med_ff});
   assign sm_acc  = $signed({2'b00, med_ff, {ptms_pkg::ALPHA_W{1'b0}}}) + sm_prod_ff
                    + $signed(SW'(ptms_pkg::ROUND_HALF));
   assign sm_res  = sm_acc[ptms_pkg::ALPHA_W +: PW];

   // rank of the scanned entry among valid entries
   logic [PW-1:0] scan_val;
   logic [FW-1:0] lt_cnt, le_cnt, mid_rank;
   assign scan_val = ring_ff[idx_ff];
   assign mid_rank = fill_ff >> 1;

   always_comb begin
      lt_cnt = '0;
      le_cnt = '0;
      for (int j = 0; j < ptms_pkg::MEDIAN_TAPS; j++) begin
         if (FW'(j) < fill_ff) begin
            if (ring_ff[j] < scan_val) begin
               lt_cnt = lt_cnt + 1'b1;
            end
            if (ring_ff[j] <= scan_val) begin
               le_cnt = le_cnt + 1'b1;
            end
         end
      end
   end

   assign status.req_zero   = (req_pitch == '0);
   assign status.track_zero = (track_ff == '0);
   assign status.fold_high  = (cand_x10 > track_x19);
   assign status.fold_low   = (cand_x19 < track_x10) && (cand_x2 <= {1'b0, max_pitch});
   assign status.scan_hit   = (lt_cnt <= mid_rank) && (le_cnt > mid_rank);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      track_in     = track_ff;
      cand_in      = cand_ff;
      med_in       = med_ff;
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         cand_in = req_pitch;
      end
      if (cmd.halve) begin
         cand_in = cand_ff >> 1;
      end
      if (cmd.double_up) begin
         cand_in = {cand_ff[PW-2:0], 1'b0};
      end
      if (cmd.decay_mul) begin
         wpos_in = '0;
         fill_in = '0;
      end
      if (cmd.decay_fin) begin
         track_in = (decay_x4 < {2'b00, min_pitch}) ? '0 : decay_q;
      end
      if (cmd.push) begin
         wpos_in = (wpos_ff == IW'(ptms_pkg::MEDIAN_TAPS - 1)) ? '0 : wpos_ff + 1'b1;
         if (fill_ff != FW'(ptms_pkg::MEDIAN_TAPS)) begin
            fill_in = fill_ff + 1'b1;
         end
         idx_in = '0;
      end
      if (cmd.scan) begin
         idx_in = idx_ff + 1'b1;
         if (status.scan_hit) begin
            med_in = scan_val;
         end
      end
      if (cmd.seed) begin
         track_in = med_ff;
      end
      if (cmd.smooth_fin) begin
         track_in = sm_res;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff     <= '0;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         track_ff     <= track_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      med_ff  <= med_in;
      idx_ff  <= idx_in;
      if (cmd.push) begin
         ring_ff[wpos_ff] <= cand_ff;
      end
      if (cmd.decay_mul) begin
         decay_prod_ff <= ptms_pkg::DECAY_PROD_W'(track_ff) *
                          ptms_pkg::DECAY_PROD_W'(ptms_pkg::DECAY_MULT);
      end
      if (cmd.smooth_mul) begin
         sm_prod_ff <= SW'($signed({1'b0, smooth_alpha}) * sm_diff);
      end
      if (cmd.emit) begin
         rsp_pitch_ff <= track_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pitch = rsp_pitch_ff;

   // while the ring is not full, the write slot sits right after the last valid entry
   a_wpos_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff < FW'(ptms_pkg::MEDIAN_TAPS)) |-> (wpos_ff == IW'(fill_ff)))
      else $error("ring write position out of step with fill");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(ptms_pkg::MEDIAN_TAPS))
      else $error("ring fill above tap count");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (fill_ff != '0))
      else $error("push left ring empty");

   a_smooth_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.smooth_fin |=> (track_ff != '0))
      else $error("smoothing of two nonzero pitches gave zero");

endmodule

// ===== hw/rtl/pitch_track_median_smoother.sv =====
// ----------------------------------------------------------------------------
// pitch_track_median_smoother
// Frame pitch tracker: octave fold, median over recent frames, exponential
// smoothing, decay on unvoiced frames.
// ----------------------------------------------------------------------------
// One beat in (raw pitch, 1/16 Hz, zero = unvoiced) gives one beat out (the
// tracked pitch). Frames are handled one at a time by a sequencer. An
// unvoiced frame runs a decay multiply and a decay finish; a voiced frame
// with a pitch already tracked runs the octave halving and doubling steps
// (one per cycle, at most 20 each), a ring push, the median scan (one ring
// entry ranked per cycle), a smoothing multiply and a smoothing finish; a
// voiced frame with no pitch tracked skips the fold and seeds instead of
// smoothing. Each frame ends by loading the result into the output
// register; a stalled output beat adds its wait before the result loads.
// A new frame is taken the cycle after the result is loaded into the output
// register, even if that beat has not been taken yet. Registers (min_pitch,
// max_pitch, smooth_alpha) are written through the csr port, ready always
// high; write them only while the block is idle.
// ----------------------------------------------------------------------------
module pitch_track_median_smoother (
   input  logic       clock,
   input  logic       reset,
   ptms_req_if.sink   req_ch,
   ptms_rsp_if.source rsp_ch,
   ptms_csr_if.sink   csr_ch
);

   // configuration registers
   logic [ptms_pkg::PITCH_W-1:0] min_pitch_ff;
   logic [ptms_pkg::PITCH_W-1:0] max_pitch_ff;
   logic [ptms_pkg::ALPHA_W-1:0] smooth_alpha_ff;

   ptms_pkg::dp_cmd_type    cmd;
   ptms_pkg::dp_status_type status;

   // every register write is accepted, so the port never stalls
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pitch_ff    <= ptms_pkg::MIN_PITCH_RST;
         max_pitch_ff    <= ptms_pkg::MAX_PITCH_RST;
         smooth_alpha_ff <= ptms_pkg::SMOOTH_ALPHA_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            ptms_pkg::CSR_MIN_PITCH: begin
               min_pitch_ff <= csr_ch.wdata[ptms_pkg::PITCH_W-1:0];
            end
            ptms_pkg::CSR_MAX_PITCH: begin
               max_pitch_ff <= csr_ch.wdata[ptms_pkg::PITCH_W-1:0];
            end
            ptms_pkg::CSR_SMOOTH_ALPHA: begin
               smooth_alpha_ff <= csr_ch.wdata[ptms_pkg::ALPHA_W-1:0];
            end
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   // sequencer: owns the input handshake, drives one command set per cycle
   ptms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: state, arithmetic and the output register
   ptms_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_pitch    (req_ch.candidate_pitch),
      .min_pitch    (min_pitch_ff),
      .max_pitch    (max_pitch_ff),
      .smooth_alpha (smooth_alpha_ff),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_pitch    (rsp_ch.tracked_pitch)
   );

endmodule
